@@ design/snd_rf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sound register file: window geometry, special offsets,
// access codes and the per-offset read mask table. No dependencies.
package snd_rf_pkg;

    // window geometry
    localparam logic [15:0] WIN_BASE = 16'hFF10;
    localparam logic [15:0] WIN_LAST = 16'hFF3F;
    localparam int          WIN_SIZE = 48;
    localparam int          OFF_W    = $clog2(WIN_SIZE);

    // offsets with side effects on the power register
    localparam logic [OFF_W-1:0] OFF_PWR  = OFF_W'(6'h16);
    localparam logic [OFF_W-1:0] OFF_CH1  = OFF_W'(6'h02);
    localparam logic [OFF_W-1:0] OFF_CH2  = OFF_W'(6'h07);
    localparam logic [OFF_W-1:0] OFF_CH3  = OFF_W'(6'h0A);
    localparam logic [OFF_W-1:0] OFF_CH4  = OFF_W'(6'h11);

    // value read back outside the window
    localparam logic [7:0] OPEN_BUS = 8'hFF;

    // access kind
    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    // bits that always read as one, per offset
    localparam logic [7:0] READ_MASK [WIN_SIZE] = '{
        8'h80, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00,
        8'hFF, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF,
        8'hFF, 8'h00, 8'h00, 8'hBF, 8'h00, 8'h00, 8'h70, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

@@ design/sound_register_file_access.sv @@
`timescale 1ns / 1ps
// Top level of the sound register file: bus access decode, register storage,
// power and channel-enable side effects, masked read-back. Uses snd_rf_pkg.

// Sound register file at 0xFF10..0xFF3F. One bus word (cmd, address,
// write_data) can be taken every clock cycle. Writes complete at the edge they
// are taken and produce no result word. A read produces one read_data word,
// presented once it has passed the registered memory read and then the result
// register, where it is held while out_stall is set. Every word, read or
// write, is held off while a read sits in the read stage and cannot move on.
// That happens only when the result register is full and stalled.
// Writing the power register with bit 7 clear wipes the whole file by
// clearing the per-entry valid bits; the storage itself needs no clearing
// pass and is ready right after reset. Reads of write-only and unused
// addresses return 0xFF, as do reads outside the window.
module sound_register_file_access
(
    input  logic        clk,
    input  logic        rst_n,
    // access channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    // read result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data
);
    import snd_rf_pkg::*;

    logic [7:0]          mem [WIN_SIZE];
    logic [7:0]          mem_q_reg;
    logic [WIN_SIZE-1:0] ent_valid_reg;
    logic [WIN_SIZE-1:0] ent_valid_next;
    logic [7:0]          pwr_reg;
    logic [7:0]          pwr_next;

    logic                s1_full_reg;
    logic                s1_full_next;
    logic                s1_inwin_reg;
    logic                s1_ent_valid_reg;
    logic [OFF_W-1:0]    s1_off_reg;
    logic [7:0]          s1_pwr_reg;
    logic                s1_move;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          read_data_reg;
    logic [7:0]          rd_byte;

    logic                in_acc;
    logic                inwin;
    logic [15:0]         off_full;
    logic [OFF_W-1:0]    off;
    logic                wr_acc;
    logic                rd_acc;
    logic                mem_we;

    // address decode
    assign inwin    = (address >= WIN_BASE) && (address <= WIN_LAST);
    assign off_full = address - WIN_BASE;
    assign off      = inwin ? off_full[OFF_W-1:0] : '0;

    // handshake
    assign s1_move  = s1_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_full_reg && !s1_move;
    assign in_acc   = in_valid && !in_stall;
    assign wr_acc   = in_acc && (cmd == CMD_WRITE) && inwin;
    assign rd_acc   = in_acc && (cmd == CMD_READ);
    assign mem_we   = wr_acc && (off != OFF_PWR);

    // storage array, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[off] <= write_data;
        end
        if (rd_acc)
        begin
            mem_q_reg <= mem[off];
        end
    end

    // entry valid bits and power register update
    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        pwr_next       = pwr_reg;
        if (mem_we)
        begin
            ent_valid_next[off] = 1'b1;
        end
        if (wr_acc)
        begin
            case (off)
                OFF_PWR:
                begin
                    if (write_data[7])
                    begin
                        pwr_next = write_data;
                    end
                    else
                    begin
                        pwr_next       = '0;
                        ent_valid_next = '0;
                    end
                end
                OFF_CH1:
                begin
                    if (write_data[7:3] == '0)
                    begin
                        pwr_next[0] = 1'b0;
                    end
                end
                OFF_CH2:
                begin
                    if (write_data[7:3] == '0)
                    begin
                        pwr_next[1] = 1'b0;
                    end
                end
                OFF_CH3:
                begin
                    if (!write_data[7])
                    begin
                        pwr_next[2] = 1'b0;
                    end
                end
                OFF_CH4:
                begin
                    if (write_data[7:3] == '0)
                    begin
                        pwr_next[3] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            pwr_reg       <= '0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            pwr_reg       <= pwr_next;
        end
    end

    // read stage control
    always_comb
    begin
        s1_full_next = s1_full_reg;
        if (rd_acc)
        begin
            s1_full_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_full_reg <= 1'b0;
        end
        else
        begin
            s1_full_reg <= s1_full_next;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (rd_acc)
        begin
            s1_inwin_reg     <= inwin;
            s1_off_reg       <= off;
            s1_ent_valid_reg <= ent_valid_reg[off];
            s1_pwr_reg       <= pwr_reg;
        end
    end

    // masked read byte
    always_comb
    begin
        if (!s1_inwin_reg)
        begin
            rd_byte = OPEN_BUS;
        end
        else if (s1_off_reg == OFF_PWR)
        begin
            rd_byte = s1_pwr_reg | READ_MASK[s1_off_reg];
        end
        else if (s1_ent_valid_reg)
        begin
            rd_byte = mem_q_reg | READ_MASK[s1_off_reg];
        end
        else
        begin
            rd_byte = READ_MASK[s1_off_reg];
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            read_data_reg <= rd_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    // power off leaves nothing behind
    a_pwr_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_acc && (off == OFF_PWR) && !write_data[7])
        |=> (pwr_reg == '0) && (ent_valid_reg == '0))
        else $error("power-off write did not clear the register file");

    // channel bits cannot stay set without the power bit
    a_pwr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !pwr_reg[7] |-> (pwr_reg == '0))
        else $error("channel active bits set while powered off");

    // channel 1 dac off drops its active bit
    a_ch1_dac_off: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_acc && (off == OFF_CH1) && (write_data[7:3] == '0))
        |=> !pwr_reg[0])
        else $error("channel 1 active bit survived dac off");

    // a read on an empty path moves through the read stage into the result register
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_acc && !s1_full_reg && !out_valid_reg)
        |=> s1_full_reg ##1 out_valid_reg)
        else $error("read result did not reach the output in time");

endmodule

@@ sim/sound_register_file_access_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sound register file: queued bus words, a shadow
// copy of the 48-byte window, read-back checks in order. Uses snd_rf_pkg.
module sound_register_file_access_test;

    import snd_rf_pkg::*;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } bus_word_t;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        cmd        = 1'b0;
    logic [15:0] address    = 16'h0000;
    logic [7:0]  write_data = 8'h00;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  read_data;

    bus_word_t   pending_words [$];
    logic [7:0]  expected_reads [$];
    logic [7:0]  shadow_regs [WIN_SIZE];
    bus_word_t   drive_word;
    pace_t       pace = PACE_FULL;
    int          words_taken = 0;
    int          total_words = 0;
    int          errors = 0;

    sound_register_file_access dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("sound_register_file_access_test NOT OK");
        $finish;
    end

    // shadow window update for one accepted word, queues the read-back byte
    task automatic apply_access(input bus_word_t w);
        logic             in_window;
        logic [OFF_W-1:0] off;
        in_window = (w.address >= WIN_BASE) && (w.address <= WIN_LAST);
        off = OFF_W'(w.address - WIN_BASE);
        if (w.cmd == CMD_WRITE)
        begin
            if (in_window)
            begin
                shadow_regs[off] = w.write_data;
                if (off == OFF_PWR)
                begin
                    // power off wipes everything; power keeps bit 7, clear here
                    if (!w.write_data[7])
                    begin
                        for (int i = 0; i < WIN_SIZE; i++)
                        begin
                            shadow_regs[i] = 8'h00;
                        end
                    end
                end
                else if (off == OFF_CH1 && w.write_data[7:3] == 5'd0)
                begin
                    shadow_regs[OFF_PWR][0] = 1'b0;
                end
                else if (off == OFF_CH2 && w.write_data[7:3] == 5'd0)
                begin
                    shadow_regs[OFF_PWR][1] = 1'b0;
                end
                else if (off == OFF_CH3 && !w.write_data[7])
                begin
                    shadow_regs[OFF_PWR][2] = 1'b0;
                end
                else if (off == OFF_CH4 && w.write_data[7:3] == 5'd0)
                begin
                    shadow_regs[OFF_PWR][3] = 1'b0;
                end
            end
        end
        else if (in_window)
        begin
            expected_reads.push_back(shadow_regs[off] | READ_MASK[off]);
        end
        else
        begin
            expected_reads.push_back(OPEN_BUS);
        end
    endtask

    task automatic queue_word(input cmd_t c, input logic [15:0] a, input logic [7:0] d);
        bus_word_t w;
        w.cmd = c;
        w.address = a;
        w.write_data = d;
        pending_words.push_back(w);
    endtask

    function automatic int send_idle_pct(input pace_t p);
        case (p)
            PACE_SEND_IDLE: return 72;
            PACE_BOTH:      return 25;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input pace_t p);
        case (p)
            PACE_RECV_STALL: return 72;
            PACE_BOTH:       return 25;
            default:         return 0;
        endcase
    endfunction

    // access driver: takes the next queued word once the current one is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                apply_access(drive_word);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct(pace))
                begin
                    drive_word = pending_words.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= drive_word.cmd;
                    address    <= drive_word.address;
                    write_data <= drive_word.write_data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            // rotate pacing every 120 words, full speed once everything is in
            if (words_taken >= total_words)
                pace <= PACE_FULL;
            else
                pace <= pace_t'((words_taken / 120) % 4);
        end
    end

    // read result monitor and receiver stall
    always @(posedge clk)
    begin : result_check
        logic [7:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                $error("read_data: no read pending, got %h", read_data);
                errors++;
            end
            else
            begin
                want = expected_reads.pop_front();
                if (read_data !== want)
                begin
                    $error("read_data: expected %h, got %h", want, read_data);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct(pace));
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [15:0] a;
        logic [7:0]  d;
        int          kind;
        int          pick;

        for (int i = 0; i < WIN_SIZE; i++)
        begin
            shadow_regs[i] = 8'h00;
        end

        // directed: address extremes, power on, each channel dac off
        queue_word(CMD_READ,  16'h0000, 8'h00);
        queue_word(CMD_WRITE, 16'hFFFF, 8'hFF);
        queue_word(CMD_WRITE, 16'hFF26, 8'hFF);
        queue_word(CMD_READ,  16'hFF26, 8'h00);
        queue_word(CMD_WRITE, 16'hFF12, 8'h07);
        queue_word(CMD_WRITE, 16'hFF17, 8'h00);
        queue_word(CMD_WRITE, 16'hFF1A, 8'h7F);
        queue_word(CMD_READ,  16'hFF26, 8'hFF);
        queue_word(CMD_WRITE, 16'hFF21, 8'h08);
        queue_word(CMD_READ,  16'hFF26, 8'h00);
        queue_word(CMD_WRITE, 16'hFF21, 8'h00);
        queue_word(CMD_READ,  16'hFF26, 8'h00);
        // wave ram, unused offset, window edges
        queue_word(CMD_WRITE, 16'hFF30, 8'hA5);
        queue_word(CMD_WRITE, 16'hFF3F, 8'h5A);
        queue_word(CMD_WRITE, 16'hFF27, 8'h12);
        queue_word(CMD_WRITE, 16'hFF10, 8'hFF);
        queue_word(CMD_READ,  16'hFF30, 8'h00);
        queue_word(CMD_READ,  16'hFF3F, 8'h00);
        queue_word(CMD_READ,  16'hFF27, 8'h00);
        queue_word(CMD_READ,  16'hFF10, 8'h00);
        // power off clears the file
        queue_word(CMD_WRITE, 16'hFF26, 8'h7F);
        queue_word(CMD_READ,  16'hFF30, 8'h00);
        queue_word(CMD_READ,  16'hFF26, 8'h00);
        queue_word(CMD_READ,  16'hFF0F, 8'h00);
        queue_word(CMD_WRITE, 16'hFF40, 8'h00);
        queue_word(CMD_READ,  16'hFF40, 8'h00);

        // random traffic, mostly inside the window
        while (pending_words.size() < 1925)
        begin
            kind = $urandom_range(0, 99);
            a = WIN_BASE + 16'($urandom_range(0, WIN_SIZE - 1));
            d = 8'($urandom_range(0, 255));
            if (kind < 40)
            begin
                queue_word(CMD_READ, a, d);
            end
            else if (kind < 75)
            begin
                queue_word(CMD_WRITE, a, d);
            end
            else if (kind < 83)
            begin
                // side-effect offsets, data leaning toward the interesting cases
                pick = $urandom_range(0, 4);
                case (pick)
                    0:
                    begin
                        a = WIN_BASE + 16'(OFF_PWR);
                        if ($urandom_range(0, 9) != 0)
                            d[7] = 1'b1;
                    end
                    1: a = WIN_BASE + 16'(OFF_CH1);
                    2: a = WIN_BASE + 16'(OFF_CH2);
                    3: a = WIN_BASE + 16'(OFF_CH3);
                    default: a = WIN_BASE + 16'(OFF_CH4);
                endcase
                if (pick != 0 && $urandom_range(0, 1) == 1)
                    d = 8'($urandom_range(0, 7));
                queue_word(CMD_WRITE, a, d);
                if ($urandom_range(0, 1) == 1)
                    queue_word(CMD_READ, WIN_BASE + 16'(OFF_PWR), 8'($urandom_range(0, 255)));
            end
            else if (kind < 90)
            begin
                // write then read back the same byte
                queue_word(CMD_WRITE, a, d);
                queue_word(CMD_READ, a, 8'($urandom_range(0, 255)));
            end
            else if (kind < 96)
            begin
                queue_word(cmd_t'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), d);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       a = 16'hFF0F;
                    1:       a = 16'hFF40;
                    2:       a = 16'h0000;
                    default: a = 16'hFFFF;
                endcase
                queue_word(cmd_t'($urandom_range(0, 1)), a, d);
            end
        end
        total_words = pending_words.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain, then leave room for a stray result
        while (words_taken < total_words || expected_reads.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("sound_register_file_access_test OK");
        else
            $display("sound_register_file_access_test NOT OK");
        $finish;
    end

endmodule
